>>> hw/rtl/substring_first_match_finder_defines.svh
// Assertion macros used by the checker of the search block.
`ifndef SUBSTRING_FIRST_MATCH_FINDER_DEFINES_SVH
`define SUBSTRING_FIRST_MATCH_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define SFMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfmf check failed");

// Next-cycle implication.
`define SFMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfmf check failed");

`endif

>>> hw/rtl/sfmf_pkg.sv
package sfmf_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65536;

   localparam int PLEN_W = $clog2(PATTERN_MAX + 1);
   localparam int TCNT_W = $clog2(TEXT_MAX + 1);
   localparam int CMP_W  = (TCNT_W > PLEN_W) ? TCNT_W : PLEN_W;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 16;
   localparam int ERR_W  = 2;
   localparam int MODE_W = 2;
   localparam int RSP_FIELDS_W = 1 + POS_W + ERR_W;
   localparam int RSP_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_CLEAR   = 2'd0,
      MODE_PATTERN = 2'd1,
      MODE_TEXT    = 2'd2,
      MODE_END     = 2'd3
   } sfmf_mode_type;

   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_PATTERN = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TEXT    = 2'd2;

   // Control broadcast along the cell chain
   typedef struct packed {
      logic              clear;
      logic              text_shift;
      logic              pat_shift;
      logic [BYTE_W-1:0] data;
   } sfmf_chain_ctl_type;

endpackage

>>> hw/rtl/substring_first_match_finder.sv
// An end-of-text transfer gives its result on rsp in the cycle after acceptance.
// Throughput: one input transfer per cycle; text bytes compare in a chain of cells,
// one cell per pattern byte, every cell checking its own window byte in the same cycle.
// req_tready drops only for an end-of-text transfer while an untaken result is held.
// Reset (synchronous, active high) empties the pattern, window, counters and output.
module substring_first_match_finder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,  // [7:0] data_byte
   input  logic [sfmf_pkg::MODE_W-1:0] req_tuser,  // [1:0] mode
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [sfmf_pkg::RSP_W-1:0]  rsp_tdata   // [0] found, [16:1] position,
                                                   // [18:17] error_code
);
   import sfmf_pkg::*;

   sfmf_mode_type      mode;
   logic               accept;
   sfmf_chain_ctl_type ctl;
   logic               all_hit;

   logic [PLEN_W-1:0] plen_ff, plen_in;
   logic [TCNT_W-1:0] tcnt_ff, tcnt_in;
   logic              seen_ff, seen_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic              povf_ff, povf_in;
   logic              tovf_ff, tovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [TCNT_W-1:0] tcnt_next;
   logic [CMP_W-1:0]  tcnt_wide;
   logic [CMP_W-1:0]  plen_wide;
   logic              text_full;
   logic              pat_full;
   logic              res_found;
   logic [POS_W-1:0]  res_pos;
   logic [ERR_W-1:0]  res_err;

   assign mode       = sfmf_mode_type'(req_tuser);
   assign req_tready = !rsp_valid_ff || rsp_tready || (mode != MODE_END);
   assign accept     = req_tvalid && req_tready;

   assign tcnt_next = tcnt_ff + 1'b1;
   assign tcnt_wide = CMP_W'(tcnt_next);
   assign plen_wide = CMP_W'(plen_ff);
   assign text_full = (tcnt_ff == TCNT_W'(TEXT_MAX));
   assign pat_full  = (plen_ff == PLEN_W'(PATTERN_MAX));

   // chain control decode
   always_comb begin
      ctl            = '0;
      ctl.data       = req_tdata;
      if (accept) begin
         unique case (mode)
            MODE_CLEAR:   ctl.clear      = 1'b1;
            MODE_PATTERN: ctl.pat_shift  = !pat_full;
            MODE_TEXT:    ctl.text_shift = !text_full;
            MODE_END:     ;
            default:      ;
         endcase
      end
   end

   sfmf_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .plen    (plen_ff),
      .all_hit (all_hit)
   );

   // result of an end-of-text transfer
   always_comb begin
      res_found = 1'b0;
      res_pos   = '0;
      res_err   = ERR_NONE;
      if (povf_ff) begin
         res_err = ERR_PATTERN;
      end else if (tovf_ff) begin
         res_err = ERR_TEXT;
      end else if (plen_ff == '0) begin
         res_found = 1'b1;
      end else if (seen_ff) begin
         res_found = 1'b1;
         res_pos   = start_ff;
      end
   end

   always_comb begin
      plen_in  = plen_ff;
      tcnt_in  = tcnt_ff;
      seen_in  = seen_ff;
      start_in = start_ff;
      povf_in  = povf_ff;
      tovf_in  = tovf_ff;
      if (accept) begin
         unique case (mode)
            MODE_CLEAR: begin
               plen_in  = '0;
               tcnt_in  = '0;
               seen_in  = 1'b0;
               start_in = '0;
               povf_in  = 1'b0;
               tovf_in  = 1'b0;
            end
            MODE_PATTERN: begin
               if (pat_full) begin
                  povf_in = 1'b1;
               end else begin
                  plen_in = plen_ff + 1'b1;
               end
            end
            MODE_TEXT: begin
               if (text_full) begin
                  tovf_in = 1'b1;
               end else begin
                  tcnt_in = tcnt_next;
                  if (!seen_ff && (plen_ff != '0) && (plen_wide <= tcnt_wide) && all_hit) begin
                     seen_in  = 1'b1;
                     start_in = POS_W'(tcnt_wide - plen_wide);
                  end
               end
            end
            MODE_END: ;
            default:  ;
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept && (mode == MODE_END)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({res_err, res_pos, res_found});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff      <= '0;
         tcnt_ff      <= '0;
         seen_ff      <= 1'b0;
         start_ff     <= '0;
         povf_ff      <= 1'b0;
         tovf_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         tcnt_ff      <= tcnt_in;
         seen_ff      <= seen_in;
         start_ff     <= start_in;
         povf_ff      <= povf_in;
         tovf_ff      <= tovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hw/rtl/sfmf_cell.sv
module sfmf_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  sfmf_pkg::sfmf_chain_ctl_type ctl,
   input  logic [sfmf_pkg::BYTE_W-1:0] win_in,
   input  logic [sfmf_pkg::BYTE_W-1:0] pat_in,
   input  logic                        active,
   output logic [sfmf_pkg::BYTE_W-1:0] win_out,
   output logic [sfmf_pkg::BYTE_W-1:0] pat_out,
   output logic                        hit
);
   import sfmf_pkg::*;

   logic [BYTE_W-1:0] win_ff, win_in_nxt;
   logic [BYTE_W-1:0] pat_ff;

   always_comb begin
      win_in_nxt = win_ff;
      if (ctl.clear) begin
         win_in_nxt = '0;
      end else if (ctl.text_shift) begin
         win_in_nxt = win_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else begin
         win_ff <= win_in_nxt;
      end
   end

   // pattern byte store, no reset: only entries below the length are compared
   always_ff @(posedge clock) begin
      if (ctl.pat_shift) begin
         pat_ff <= pat_in;
      end
   end

   // compare against the byte arriving this cycle, i.e. the window after the shift
   assign hit     = !active || (win_in == pat_ff);
   assign win_out = win_ff;
   assign pat_out = pat_ff;

endmodule

>>> hw/rtl/sfmf_chain.sv
module sfmf_chain (
   input  logic                         clock,
   input  logic                         reset,
   input  sfmf_pkg::sfmf_chain_ctl_type ctl,
   input  logic [sfmf_pkg::PLEN_W-1:0]  plen,
   output logic                         all_hit
);
   import sfmf_pkg::*;

   // cell k holds the text byte of age k and pattern byte plen-1-k
   logic [BYTE_W-1:0]      win_link [PATTERN_MAX+1];
   logic [BYTE_W-1:0]      pat_link [PATTERN_MAX+1];
   logic [PATTERN_MAX-1:0] hit_vec;
   logic [PATTERN_MAX-1:0] active_vec;

   assign win_link[0] = ctl.data;
   assign pat_link[0] = ctl.data;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      assign active_vec[k] = (PLEN_W'(k) < plen);

      sfmf_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .win_in  (win_link[k]),
         .pat_in  (pat_link[k]),
         .active  (active_vec[k]),
         .win_out (win_link[k+1]),
         .pat_out (pat_link[k+1]),
         .hit     (hit_vec[k])
      );
   end

   assign all_hit = &hit_vec;

endmodule

>>> hw/rtl/sfmf_checker.sv
module sfmf_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic [sfmf_pkg::MODE_W-1:0] req_tuser,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [sfmf_pkg::RSP_W-1:0]  rsp_tdata
);
   import sfmf_pkg::*;
   `include "substring_first_match_finder_defines.svh"

   // held result stays put until taken
   `SFMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // an accepted end of text always shows a result next cycle
   `SFMF_ASSERT_NEXT(a_end_gives_rsp, clock, reset, req_tvalid && req_tready && (req_tuser == MODE_END), rsp_tvalid)

   // a found result carries no error
   `SFMF_ASSERT_NOW(a_found_no_err, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[18:17] == ERR_NONE)

   // no match means position zero
   `SFMF_ASSERT_NOW(a_miss_pos_zero, clock, reset, rsp_tvalid && !rsp_tdata[0], rsp_tdata[16:1] == '0)

endmodule

bind substring_first_match_finder sfmf_checker u_sfmf_checker (.*);
